/* rtl/core/ascii_escape_encoder_top_macros.svh */
// Assertion macros used by the checker file of the escape encoder.
`ifndef ASCII_ESCAPE_ENCODER_TOP_MACROS_SVH
`define ASCII_ESCAPE_ENCODER_TOP_MACROS_SVH

// Generic clocked assertion, disabled while reset is asserted.
`define AEE_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A signal holds its value while its beat is offered and not taken.
`define AEE_ASSERT_HOLD(lbl, vld, rdy, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (vld && !rdy) |=> $stable(sig)) else $error(msg);

`endif

/* rtl/core/aee_pkg.sv */
// Package with types, constants and helpers of the escape encoder.
`timescale 1ns / 1ps
`default_nettype none

package aee_pkg;

    localparam int CP_W        = 21;
    localparam int UNIT_W      = 16;
    localparam int STEP_W      = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0]      BACKSLASH      = 8'h5C;
    localparam logic [STEP_W-1:0] UNIT_STEPS   = STEP_W'(5);
    localparam logic [STEP_W-1:0] LAST_STEP_BMP  = STEP_W'(4);
    localparam logic [STEP_W-1:0] LAST_STEP_PAIR = STEP_W'(9);

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_UNSUP   = 2'd2
    } status_t;

    // SINGLE gives one result; BMP one escaped unit; PAIR two escaped units.
    typedef enum logic [1:0] {
        CMD_SINGLE,
        CMD_BMP,
        CMD_PAIR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [7:0]         single_byte;
        status_t            single_status;
        logic [UNIT_W-1:0]  unit_hi;
        logic [UNIT_W-1:0]  unit_lo;
    } aee_cmd_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ext;
        ext = {4'd0, nib};
        hex_char = (nib < 4'd10) ? (8'h30 + ext) : (8'h37 + ext);
    endfunction

endpackage

`default_nettype wire

/* rtl/core/ascii_escape_encoder_top.sv */
// Top level of the ASCII escape encoder.
//
//  Channel   Handshake               Payload
//  cp        cp_valid / cp_ready     code_point[20:0]
//  res       res_valid / res_ready   out_byte[7:0], last_of_run, status[1:0]
//  cfg       cfg_wr_en               cfg_wr_data (dest_ascii_compatible)
//
// Each code point gives one result beat for plain ASCII and errors, five for a BMP
// escape, ten for a surrogate pair; the byte sequencer sends one per cycle unless stalled.
// A code point is taken in the cycle it arrives while the command queue has room,
// so the next one is classified while the previous one is still being emitted.
// A result beat is registered from the command at the queue head once the output is free.
// Reset is asynchronous and active low; the charset flag resets to one.
`timescale 1ns / 1ps
`default_nettype none

module ascii_escape_encoder_top
    import aee_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cp_valid,
    output logic                 cp_ready,
    input  wire logic [CP_W-1:0] code_point,
    output logic                 res_valid,
    input  wire logic            res_ready,
    output logic [7:0]           out_byte,
    output logic                 last_of_run,
    output logic [1:0]           status,
    input  wire logic            cfg_wr_en,
    input  wire logic            cfg_wr_data
);

    logic     ascii_compat_reg;
    logic     push;
    logic     q_full;
    logic     pop;
    logic     head_valid;
    aee_cmd_t push_cmd;
    aee_cmd_t head_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ascii_compat_reg <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            ascii_compat_reg <= cfg_wr_data;
        end
    end

    aee_front u_front (
        .cp_valid              (cp_valid),
        .cp_ready              (cp_ready),
        .code_point            (code_point),
        .dest_ascii_compatible (ascii_compat_reg),
        .q_full                (q_full),
        .push                  (push),
        .cmd                   (push_cmd)
    );

    aee_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    aee_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_cmd    (head_cmd),
        .pop         (pop),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .status      (status)
    );

endmodule

`default_nettype wire

/* rtl/core/aee_front.sv */
// Front end: accepts code points and classifies them into byte commands.
`timescale 1ns / 1ps
`default_nettype none

module aee_front
    import aee_pkg::*;
(
    input  wire logic            cp_valid,
    output logic                 cp_ready,
    input  wire logic [CP_W-1:0] code_point,
    input  wire logic            dest_ascii_compatible,
    input  wire logic            q_full,
    output logic                 push,
    output aee_cmd_t             cmd
);

    logic            is_plain;
    logic            is_invalid;
    logic [CP_W-1:0] offset;

    assign cp_ready = !q_full;
    assign push     = cp_valid && !q_full;

    always_comb
    begin
        is_plain   = (code_point < CP_W'(8'h80)) && (code_point[7:0] != BACKSLASH);
        is_invalid = (code_point > CP_W'(32'h10FFFF))
                  || ((code_point >= CP_W'(16'hD800)) && (code_point <= CP_W'(16'hDFFF)));
        offset     = code_point - CP_W'(32'h10000);

        cmd.kind          = CMD_SINGLE;
        cmd.single_byte   = 8'd0;
        cmd.single_status = ST_OK;
        cmd.unit_hi       = code_point[UNIT_W-1:0];
        cmd.unit_lo       = {6'b110111, offset[9:0]};

        if (is_plain)
        begin
            cmd.single_byte = code_point[7:0];
        end
        else if (is_invalid)
        begin
            cmd.single_status = ST_INVALID;
        end
        else if (!dest_ascii_compatible)
        begin
            cmd.single_status = ST_UNSUP;
        end
        else if (code_point[CP_W-1:UNIT_W] == '0)
        begin
            cmd.kind = CMD_BMP;
        end
        else
        begin
            // Supplementary plane: split into a high and a low surrogate.
            cmd.kind    = CMD_PAIR;
            cmd.unit_hi = {6'b110110, offset[19:10]};
        end
    end

endmodule

`default_nettype wire

/* rtl/core/aee_queue.sv */
// Short command queue between the front end and the byte sequencer.
`timescale 1ns / 1ps
`default_nettype none

module aee_queue
    import aee_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire aee_cmd_t push_cmd,
    output logic          full,
    input  wire logic     pop,
    output logic          head_valid,
    output aee_cmd_t      head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    aee_cmd_t         entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/aee_back.sv */
// Back end: steps through a command and emits one byte per beat.
`timescale 1ns / 1ps
`default_nettype none

module aee_back
    import aee_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     head_valid,
    input  wire aee_cmd_t head_cmd,
    output logic          pop,
    output logic          res_valid,
    input  wire logic     res_ready,
    output logic [7:0]    out_byte,
    output logic          last_of_run,
    output logic [1:0]    status
);

    logic [STEP_W-1:0] step_reg, step_next;
    logic              res_valid_reg, res_valid_next;
    logic [7:0]        byte_reg, byte_next;
    logic              last_reg, last_next;
    status_t           status_reg, status_next;

    logic              load;
    logic              upper;
    logic [UNIT_W-1:0] unit;
    logic [STEP_W-1:0] pos;

    // The output register is free when empty or when its beat is taken now.
    assign load = head_valid && (!res_valid_reg || res_ready);
    assign pop  = load && last_next;

    always_comb
    begin
        upper = (step_reg >= UNIT_STEPS);
        unit  = upper ? head_cmd.unit_lo : head_cmd.unit_hi;
        pos   = upper ? (step_reg - UNIT_STEPS) : step_reg;

        byte_next   = BACKSLASH;
        status_next = ST_OK;
        case (pos)
            STEP_W'(1): byte_next = hex_char(unit[15:12]);
            STEP_W'(2): byte_next = hex_char(unit[11:8]);
            STEP_W'(3): byte_next = hex_char(unit[7:4]);
            STEP_W'(4): byte_next = hex_char(unit[3:0]);
            default:    byte_next = BACKSLASH;
        endcase

        case (head_cmd.kind)
            CMD_SINGLE:
            begin
                byte_next   = head_cmd.single_byte;
                status_next = head_cmd.single_status;
                last_next   = 1'b1;
            end
            CMD_BMP:  last_next = (step_reg == LAST_STEP_BMP);
            CMD_PAIR: last_next = (step_reg == LAST_STEP_PAIR);
            default:  last_next = 1'b1;
        endcase

        step_next      = step_reg;
        res_valid_next = res_valid_reg;
        if (load)
        begin
            step_next      = last_next ? '0 : step_reg + 1'b1;
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg   <= byte_next;
            last_reg   <= last_next;
            status_reg <= status_next;
        end
    end

    assign res_valid   = res_valid_reg;
    assign out_byte    = byte_reg;
    assign last_of_run = last_reg;
    assign status      = status_reg;

endmodule

`default_nettype wire

/* rtl/core/ascii_escape_encoder_checker.sv */
// Port-level checker for the escape encoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "ascii_escape_encoder_top_macros.svh"

module ascii_escape_encoder_checker
    import aee_pkg::*;
(
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            cp_valid,
    input wire logic            cp_ready,
    input wire logic [CP_W-1:0] code_point,
    input wire logic            res_valid,
    input wire logic            res_ready,
    input wire logic [7:0]      out_byte,
    input wire logic            last_of_run,
    input wire logic [1:0]      status
);

    // An error beat is always the only beat of its code point and carries zero.
    `AEE_ASSERT_CLK(a_err_is_last, (res_valid && status != ST_OK) |-> last_of_run, "error beat not last")
    `AEE_ASSERT_CLK(a_err_zero, (res_valid && status != ST_OK) |-> (out_byte == 8'd0), "error beat not zero")
    // The rest of an escape run follows without a gap once a beat is taken.
    `AEE_ASSERT_CLK(a_run_no_gap, (res_valid && res_ready && !last_of_run) |=> res_valid, "gap inside run")
    `AEE_ASSERT_HOLD(a_res_hold, res_valid, res_ready, out_byte, "stalled byte changed")
    `AEE_ASSERT_HOLD(a_cp_hold, cp_valid, cp_ready, code_point, "stalled code point changed")

endmodule

bind ascii_escape_encoder_top ascii_escape_encoder_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cp_valid    (cp_valid),
    .cp_ready    (cp_ready),
    .code_point  (code_point),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .status      (status)
);

`default_nettype wire

/* bench/ascii_escape_encoder_top_test.sv */
// Self-checking testbench of the ASCII escape encoder with a behavioral predictor.
`timescale 1ns / 1ps
module ascii_escape_encoder_top_test;
    import aee_pkg::*;

    localparam int HOLD_OFF_CYCLES = 120;
    localparam int SETTLE_CYCLES   = 12;
    localparam int PHASE_ITEMS     = 28;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        status_t    st;
    } escape_beat_t;

    logic            clk         = 1'b0;
    logic            rst_n       = 1'b0;
    logic            cp_valid    = 1'b0;
    logic            cp_ready;
    logic [CP_W-1:0] code_point  = '0;
    logic            res_valid;
    logic            res_ready   = 1'b0;
    logic [7:0]      out_byte;
    logic            last_of_run;
    logic [1:0]      status;
    logic            cfg_wr_en   = 1'b0;
    logic            cfg_wr_data = 1'b0;

    logic [7:0] hex_lut [0:15] = '{"0", "1", "2", "3", "4", "5", "6", "7",
                                   "8", "9", "A", "B", "C", "D", "E", "F"};

    escape_beat_t escaped_q [$];
    int           error_count    = 0;
    bit           dest_compat    = 1'b1;
    bit           sender_idle_on = 1'b0;
    bit           rx_idle_on     = 1'b0;
    bit           rx_hold        = 1'b0;
    int           rx_stall_left  = 0;

    ascii_escape_encoder_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cp_valid    (cp_valid),
        .cp_ready    (cp_ready),
        .code_point  (code_point),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .status      (status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 clk = ~clk;

    function automatic void push_beat(logic [7:0] ch, logic last, status_t st);
        escape_beat_t b;
        b.ch   = ch;
        b.last = last;
        b.st   = st;
        escaped_q.push_back(b);
    endfunction

    function automatic void push_unit(logic [15:0] unit, logic final_unit);
        push_beat(BACKSLASH, 1'b0, ST_OK);
        for (int i = 3; i >= 0; i--)
        begin
            push_beat(hex_lut[unit[4*i +: 4]], final_unit && (i == 0), ST_OK);
        end
    endfunction

    // Expected beats of one code point under the current charset flag.
    function automatic void predict_escape(logic [CP_W-1:0] cp);
        logic [19:0] offs;
        if (cp < 21'h80 && cp != CP_W'(BACKSLASH))
        begin
            push_beat(cp[7:0], 1'b1, ST_OK);
        end
        else if (cp > 21'h10FFFF || (cp >= 21'hD800 && cp <= 21'hDFFF))
        begin
            push_beat(8'h00, 1'b1, ST_INVALID);
        end
        else if (!dest_compat)
        begin
            push_beat(8'h00, 1'b1, ST_UNSUP);
        end
        else if (cp < 21'h10000)
        begin
            push_unit(cp[15:0], 1'b1);
        end
        else
        begin
            offs = 20'(cp - 21'h10000);
            push_unit({6'b110110, offs[19:10]}, 1'b0);
            push_unit({6'b110111, offs[9:0]}, 1'b1);
        end
    endfunction

    function automatic logic [CP_W-1:0] random_code_point();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            return CP_W'($urandom_range(0, 'h7F));
        else if (pick < 45)
            return CP_W'($urandom_range('h80, 'hFFFF));
        else if (pick < 70)
            return CP_W'($urandom_range('h10000, 'h10FFFF));
        else if (pick < 80)
            return CP_W'($urandom_range('hD800, 'hDFFF));
        else if (pick < 88)
            return CP_W'($urandom_range('h110000, 'h1FFFFF));
        else
            return CP_W'($urandom);
    endfunction

    // Offers one code point, holding valid across back-to-back beats.
    task automatic send_code_point(input logic [CP_W-1:0] cp);
        int gap;
        gap = 0;
        if (sender_idle_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 9);
        @(negedge clk);
        if (gap > 0)
        begin
            cp_valid   <= 1'b0;
            code_point <= CP_W'($urandom);
            repeat (gap) @(negedge clk);
        end
        cp_valid   <= 1'b1;
        code_point <= cp;
        do @(posedge clk); while (!cp_ready);
        predict_escape(cp);
    endtask

    task automatic release_input();
        @(negedge clk);
        cp_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (escaped_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_dest_compat(input bit value);
        release_input();
        wait_drained();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        dest_compat = value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic hold_receiver();
        fork
            begin
                rx_hold = 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                rx_hold = 1'b0;
            end
        join_none
    endtask

    task automatic test_directed_defaults();
        logic [CP_W-1:0] pts [17];
        pts = '{21'h000000, 21'h000041, 21'h00007F, 21'h00005C, 21'h000080,
                21'h0000FF, 21'h0007FF, 21'h00D7FF, 21'h00D800, 21'h00DFFF,
                21'h00E000, 21'h00FFFF, 21'h010000, 21'h10FFFF, 21'h110000,
                21'h1FFFFF, 21'h01F600};
        foreach (pts[i])
            send_code_point(pts[i]);
        release_input();
        wait_drained();
    endtask

    task automatic test_unsupported_dest();
        logic [CP_W-1:0] pts [8];
        pts = '{21'h000041, 21'h00005C, 21'h000080, 21'h010000,
                21'h00D800, 21'h110000, 21'h00007F, 21'h1FFFFF};
        set_dest_compat(1'b0);
        foreach (pts[i])
            send_code_point(pts[i]);
        set_dest_compat(1'b1);
    endtask

    // Receiver holds off while surrogate pairs keep coming, so the input stalls.
    task automatic test_output_stall();
        sender_idle_on = 1'b0;
        rx_idle_on     = 1'b0;
        hold_receiver();
        repeat (16)
            send_code_point(CP_W'($urandom_range('h10000, 'h10FFFF)));
        release_input();
        wait_drained();
    endtask

    // Random phases with idling on both sides; the flag changes between phases.
    task automatic test_random_mix();
        sender_idle_on = 1'b1;
        rx_idle_on     = 1'b1;
        for (int phase = 0; phase < 6; phase++)
        begin
            set_dest_compat((phase % 2 == 0) ? 1'b1 : 1'b0);
            repeat (PHASE_ITEMS)
                send_code_point(random_code_point());
        end
        set_dest_compat(1'b1);
    endtask

    task automatic test_steady_stream();
        sender_idle_on = 1'b0;
        rx_idle_on     = 1'b0;
        repeat (40)
            send_code_point(random_code_point());
        release_input();
        wait_drained();
    endtask

    always @(negedge clk)
    begin
        if (!rst_n || rx_hold)
        begin
            res_ready <= 1'b0;
        end
        else if (rx_stall_left > 0)
        begin
            res_ready <= 1'b0;
            rx_stall_left--;
        end
        else if (rx_idle_on && $urandom_range(0, 4) == 0)
        begin
            res_ready     <= 1'b0;
            rx_stall_left = $urandom_range(0, 8);
        end
        else
        begin
            res_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_beat
        escape_beat_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (escaped_q.size() == 0)
            begin
                $error("result beat with none expected: out_byte %h", out_byte);
                error_count++;
            end
            else
            begin
                want = escaped_q.pop_front();
                if (out_byte !== want.ch)
                begin
                    $error("out_byte: expected %h, actual %h", want.ch, out_byte);
                    error_count++;
                end
                if (last_of_run !== want.last)
                begin
                    $error("last_of_run: expected %b, actual %b", want.last, last_of_run);
                    error_count++;
                end
                if (status !== 2'(want.st))
                begin
                    $error("status: expected %0d, actual %0d", want.st, status);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed_defaults();
        test_unsupported_dest();
        test_output_stall();
        test_random_mix();
        test_steady_stream();
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/aee_pkg.sv
rtl/core/aee_front.sv
rtl/core/aee_queue.sv
rtl/core/aee_back.sv
rtl/core/ascii_escape_encoder_top.sv
rtl/core/ascii_escape_encoder_checker.sv
bench/ascii_escape_encoder_top_test.sv
